>>> hw/rtl/pts_pkg.sv
// Shared types and constants of the process table scheduler.
`default_nettype none
package pts_pkg;
  localparam int NUM_SLOTS = 64;
  localparam int SW = $clog2(NUM_SLOTS);
  localparam int TW = SW + 1;
  localparam logic [TW-1:0] NONE_SLOT = TW'(NUM_SLOTS);

  typedef enum logic [2:0] {
    ST_UNUSED = 3'd0, ST_EMBRYO = 3'd1, ST_SLEEPING = 3'd2,
    ST_RUNNABLE = 3'd3, ST_RUNNING = 3'd4, ST_ZOMBIE = 3'd5
  } slot_state_t;

  localparam logic [3:0] ACT_ALLOC = 4'd0;
  localparam logic [3:0] ACT_ABANDON = 4'd1;
  localparam logic [3:0] ACT_MKRUN = 4'd2;
  localparam logic [3:0] ACT_SCHED = 4'd3;
  localparam logic [3:0] ACT_YIELD = 4'd4;
  localparam logic [3:0] ACT_SLEEP = 4'd5;
  localparam logic [3:0] ACT_WAKEUP = 4'd6;
  localparam logic [3:0] ACT_KILL = 4'd7;
  localparam logic [3:0] ACT_EXIT = 4'd8;
  localparam logic [3:0] ACT_WAIT = 4'd9;

  localparam logic [2:0] STS_OK = 3'd0;
  localparam logic [2:0] STS_NOFREE = 3'd1;
  localparam logic [2:0] STS_NOTFOUND = 3'd2;
  localparam logic [2:0] STS_NOKIDS = 3'd3;
  localparam logic [2:0] STS_BLOCKED = 3'd4;
  localparam logic [2:0] STS_INITEXIT = 3'd5;
  localparam logic [2:0] STS_NONERUN = 3'd6;

  // One slot entry as stored in the table memory.
  typedef struct packed {
    slot_state_t   st;
    logic [15:0]   pid;
    logic [TW-1:0] parent;
    logic [15:0]   chan;
    logic          killed;
  } slot_t;
endpackage
`default_nettype wire

>>> hw/rtl/process_table_scheduler.sv
// Top level: process slot table with a sequencer that walks the slots.
`default_nettype none
// Each event word is applied to a 64-slot process table held in one memory
// with a single read and a single write port. Simple events (abandon, make
// runnable, yield, sleep) read the target slot and then update it. Events
// that look through the table (alloc, schedule, wakeup, kill, exit, wait)
// read each slot and then examine it. Exit makes a wake pass for the parent
// before its sweep, and one extra full pass per orphaned zombie (each wakes
// init's waiters). After reset a clearing pass writes every slot before the
// first event word is accepted. One event is worked on at a time; in_ready is
// low meanwhile. A result word waits in an output register and the next
// event is taken only after it is taken.
module process_table_scheduler
  import pts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_action,
  input  wire logic [6:0]  in_target_slot,
  input  wire logic [15:0] in_target_pid,
  input  wire logic [14:0] in_channel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [6:0]       out_result_slot,
  output logic [15:0]      out_result_pid,
  output logic [6:0]       out_woken_count
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TGT_RD, S_TGT, S_SCAN_RD, S_SCAN, S_WAKE_RD, S_WAKE,
    S_FIN_WR, S_DONE
  } fsm_t;
  // Purpose of the current table sweep.
  typedef enum logic [1:0] {
    P_MAIN, P_WAKE_PAR, P_WAKE_INIT
  } pass_t;

  slot_t mem [NUM_SLOTS];
  slot_t rd_q;
  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  slot_t         wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  fsm_t state_r, state_nxt;
  pass_t pass_r, pass_nxt;
  logic [3:0]    act_r, act_nxt;
  logic [TW-1:0] tgt_r, tgt_nxt;
  logic [15:0]   pid_r, pid_nxt;
  logic [14:0]   chan_r, chan_nxt;
  logic [15:0]   next_pid_r, next_pid_nxt;
  logic [SW-1:0] scan_pos_r, scan_pos_nxt;
  logic [TW-1:0] running_r, running_nxt, init_r, init_nxt;
  logic [SW:0]   cnt_r, cnt_nxt;       // sweep counter, may reach NUM_SLOTS
  logic [SW-1:0] resume_r, resume_nxt; // where the main exit sweep continues
  slot_t         tslot_r, tslot_nxt;   // target slot copy
  logic          kids_r, kids_nxt;
  logic [15:0]   wchan_r, wchan_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [TW-1:0] rs_r, rs_nxt;
  logic [15:0]   rp_r, rp_nxt;
  logic [6:0]    wk_r, wk_nxt;
  logic          ov_r, ov_nxt;

  logic [SW-1:0] cur;
  logic          tvalid;
  assign cur = act_r == ACT_SCHED ? SW'(scan_pos_r + cnt_r[SW-1:0]) : cnt_r[SW-1:0];
  assign tvalid = tgt_r < NONE_SLOT;
  assign in_ready = state_r == S_IDLE && !ov_r;

  always_comb begin
    state_nxt = state_r; pass_nxt = pass_r; act_nxt = act_r; tgt_nxt = tgt_r;
    pid_nxt = pid_r; chan_nxt = chan_r; next_pid_nxt = next_pid_r;
    scan_pos_nxt = scan_pos_r; running_nxt = running_r; init_nxt = init_r;
    cnt_nxt = cnt_r; resume_nxt = resume_r; tslot_nxt = tslot_r;
    kids_nxt = kids_r; wchan_nxt = wchan_r; st_nxt = st_r; rs_nxt = rs_r;
    rp_nxt = rp_r; wk_nxt = wk_r; ov_nxt = ov_r;
    rd_addr = cur; wr_en = 1'b0; wr_addr = cur; wr_data = rd_q;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_data = '{st: ST_UNUSED, pid: '0, parent: NONE_SLOT, chan: '0, killed: 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (SW+1)'(NUM_SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          act_nxt = in_action; tgt_nxt = in_target_slot[TW-1:0];
          pid_nxt = in_target_pid; chan_nxt = in_channel;
          st_nxt = STS_NOTFOUND; rs_nxt = NONE_SLOT; rp_nxt = '0; wk_nxt = '0;
          cnt_nxt = '0; kids_nxt = 1'b0; pass_nxt = P_MAIN;
          unique case (in_action)
            ACT_ALLOC, ACT_KILL, ACT_WAKEUP: state_nxt = S_SCAN_RD;
            ACT_SCHED: state_nxt = S_TGT_RD;
            ACT_ABANDON, ACT_MKRUN, ACT_YIELD, ACT_SLEEP, ACT_EXIT, ACT_WAIT:
              state_nxt = S_TGT_RD;
            default: state_nxt = S_DONE;
          endcase
          if (in_action == ACT_WAKEUP) wchan_nxt = {1'b0, in_channel};
          if (in_action == ACT_SCHED && in_target_slot[TW-1:0] == '0) tgt_nxt = '0;
        end
      end
      S_TGT_RD: begin
        // For schedule the slot read is the running one.
        rd_addr = act_r == ACT_SCHED ? running_r[SW-1:0] : tgt_r[SW-1:0];
        state_nxt = S_TGT;
      end
      S_TGT: begin
        tslot_nxt = rd_q;
        wr_addr = tgt_r[SW-1:0];
        state_nxt = S_DONE;
        if (act_r == ACT_SCHED) begin
          if (running_r < NONE_SLOT && rd_q.st == ST_RUNNING) begin
            rs_nxt = running_r; st_nxt = STS_OK;
          end else begin
            running_nxt = NONE_SLOT; st_nxt = STS_NONERUN; state_nxt = S_SCAN_RD;
          end
        end else if (tvalid) begin
          unique case (act_r)
            ACT_ABANDON: if (rd_q.st == ST_EMBRYO) begin
              wr_en = 1'b1; wr_data.st = ST_UNUSED; wr_data.parent = NONE_SLOT;
              if (init_r == tgt_r) init_nxt = NONE_SLOT;
              st_nxt = STS_OK;
            end
            ACT_MKRUN: if (rd_q.st == ST_EMBRYO) begin
              wr_en = 1'b1; wr_data.st = ST_RUNNABLE; st_nxt = STS_OK;
            end
            ACT_YIELD: if (rd_q.st == ST_RUNNING) begin
              wr_en = 1'b1; wr_data.st = ST_RUNNABLE; st_nxt = STS_OK;
              if (running_r == tgt_r) running_nxt = NONE_SLOT;
            end
            ACT_SLEEP: if (rd_q.st == ST_RUNNING) begin
              wr_en = 1'b1; wr_data.st = ST_SLEEPING; wr_data.chan = {1'b0, chan_r};
              st_nxt = STS_OK;
              if (running_r == tgt_r) running_nxt = NONE_SLOT;
            end
            ACT_EXIT: if (rd_q.st == ST_RUNNING) begin
              if (tgt_r == init_r) st_nxt = STS_INITEXIT;
              else if (rd_q.parent < NONE_SLOT) begin
                pass_nxt = P_WAKE_PAR;
                wchan_nxt = {1'b1, 15'(rd_q.parent)};
                state_nxt = S_WAKE_RD;
              end else state_nxt = S_SCAN_RD;
            end
            ACT_WAIT: if (rd_q.st == ST_RUNNING) state_nxt = S_SCAN_RD;
            default: ;
          endcase
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN;
      S_SCAN: begin
        // rd_q holds slot cur; the next address is already presented.
        state_nxt = S_SCAN_RD;
        cnt_nxt = cnt_r + 1'b1;
        unique case (act_r)
          ACT_ALLOC: if (rd_q.st == ST_UNUSED) begin
            wr_en = 1'b1; wr_data.st = ST_EMBRYO; wr_data.pid = next_pid_r;
            wr_data.parent = tvalid ? tgt_r : NONE_SLOT;
            if (init_r >= NONE_SLOT) init_nxt = {1'b0, cur};
            rs_nxt = {1'b0, cur}; rp_nxt = next_pid_r; st_nxt = STS_OK;
            next_pid_nxt = next_pid_r == 16'hFFFF ? 16'd1 : next_pid_r + 16'd1;
            state_nxt = S_DONE;
          end
          ACT_SCHED: if (rd_q.st == ST_RUNNABLE) begin
            wr_en = 1'b1; wr_data.st = ST_RUNNING; running_nxt = {1'b0, cur};
            scan_pos_nxt = cur + 1'b1; rs_nxt = {1'b0, cur}; st_nxt = STS_OK;
            state_nxt = S_DONE;
          end
          ACT_WAKEUP: if (rd_q.st == ST_SLEEPING && rd_q.chan == wchan_r) begin
            wr_en = 1'b1; wr_data.st = ST_RUNNABLE; wk_nxt = wk_r + 7'd1;
          end
          ACT_KILL: if (rd_q.pid == pid_r) begin
            wr_en = 1'b1; wr_data.killed = 1'b1; st_nxt = STS_OK;
            if (rd_q.st == ST_SLEEPING) begin
              wr_data.st = ST_RUNNABLE; wk_nxt = 7'd1;
            end
            state_nxt = S_DONE;
          end
          ACT_EXIT: if (rd_q.parent == tgt_r) begin
            wr_en = 1'b1; wr_data.parent = init_r;
            if (rd_q.st == ST_ZOMBIE && init_r < NONE_SLOT) begin
              resume_nxt = cur; pass_nxt = P_WAKE_INIT;
              wchan_nxt = {1'b1, 15'(init_r)};
              cnt_nxt = '0; state_nxt = S_WAKE_RD;
            end
          end
          ACT_WAIT: if (rd_q.parent == tgt_r) begin
            kids_nxt = 1'b1;
            if (rd_q.st == ST_ZOMBIE) begin
              wr_en = 1'b1;
              wr_data = '{st: ST_UNUSED, pid: '0, parent: NONE_SLOT,
                          chan: rd_q.chan, killed: 1'b0};
              rs_nxt = {1'b0, cur}; rp_nxt = rd_q.pid; st_nxt = STS_OK;
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
        if (state_nxt == S_SCAN_RD && cnt_r == (SW+1)'(NUM_SLOTS - 1)) begin
          unique case (act_r)
            ACT_ALLOC: st_nxt = STS_NOFREE;
            ACT_WAKEUP: st_nxt = STS_OK;
            ACT_EXIT, ACT_WAIT: state_nxt = S_FIN_WR;
            default: ;
          endcase
          if (act_r == ACT_ALLOC || act_r == ACT_SCHED || act_r == ACT_KILL ||
              act_r == ACT_WAKEUP) state_nxt = S_DONE;
        end
        rd_addr = cnt_nxt[SW-1:0];
        if (act_r == ACT_SCHED) rd_addr = SW'(scan_pos_r + cnt_nxt[SW-1:0]);
      end
      S_WAKE_RD: state_nxt = S_WAKE;
      S_WAKE: begin
        rd_addr = cnt_r[SW-1:0] + 1'b1;
        wr_addr = cnt_r[SW-1:0];
        state_nxt = S_WAKE_RD;
        cnt_nxt = cnt_r + 1'b1;
        if (rd_q.st == ST_SLEEPING && rd_q.chan == wchan_r) begin
          wr_en = 1'b1; wr_data.st = ST_RUNNABLE; wk_nxt = wk_r + 7'd1;
        end
        if (cnt_r == (SW+1)'(NUM_SLOTS - 1)) begin
          state_nxt = S_SCAN_RD;
          if (pass_r == P_WAKE_PAR) begin
            cnt_nxt = '0; rd_addr = '0;
          end else begin
            cnt_nxt = {1'b0, resume_r} + 1'b1; rd_addr = resume_r + 1'b1;
            if (resume_r == SW'(NUM_SLOTS - 1)) state_nxt = S_FIN_WR;
          end
          pass_nxt = P_MAIN;
        end
      end
      S_FIN_WR: begin
        // The sweeps only wake sleepers, and the target is running, so its copy
        // is current except for a parent field that named the target itself.
        wr_en = 1'b1; wr_addr = tgt_r[SW-1:0]; wr_data = tslot_r;
        state_nxt = S_DONE;
        if (act_r == ACT_EXIT) begin
          wr_data.st = ST_ZOMBIE; st_nxt = STS_OK;
          if (tslot_r.parent == tgt_r) wr_data.parent = init_r;
          if (running_r == tgt_r) running_nxt = NONE_SLOT;
        end else if (!kids_r || tslot_r.killed) begin
          wr_en = 1'b0; st_nxt = STS_NOKIDS;
        end else begin
          wr_data.st = ST_SLEEPING; wr_data.chan = {1'b1, 15'(tgt_r)};
          st_nxt = STS_BLOCKED;
          if (running_r == tgt_r) running_nxt = NONE_SLOT;
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; pass_r <= P_MAIN; cnt_r <= '0; next_pid_r <= 16'd1;
      scan_pos_r <= '0; running_r <= NONE_SLOT; init_r <= NONE_SLOT; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; pass_r <= pass_nxt; cnt_r <= cnt_nxt;
      next_pid_r <= next_pid_nxt; scan_pos_r <= scan_pos_nxt;
      running_r <= running_nxt; init_r <= init_nxt; ov_r <= ov_nxt;
    end
    act_r <= act_nxt; tgt_r <= tgt_nxt; pid_r <= pid_nxt; chan_r <= chan_nxt;
    resume_r <= resume_nxt; tslot_r <= tslot_nxt; kids_r <= kids_nxt;
    wchan_r <= wchan_nxt; st_r <= st_nxt; rs_r <= rs_nxt; rp_r <= rp_nxt;
    wk_r <= wk_nxt;
  end

  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_result_slot = 7'(rs_r);
  assign out_result_pid = rp_r;
  assign out_woken_count = wk_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("accept while busy");
  a_ok_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_BLOCKED |-> out_result_slot == 7'(NONE_SLOT))
    else $error("blocked wait returned a slot");
  a_pid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_pid_r != 16'd0) else $error("next pid is zero");
endmodule
`default_nettype wire
